// ----- rtl/c3s_pkg.sv -----
package c3s_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int ROW_LIMIT    = 64;
    localparam int K            = 3;
    localparam int DATA_W       = 16;
    localparam int TAPS_W       = K * DATA_W;
    localparam int DIM_W        = 7;
    localparam int ROW_W        = $clog2(ROW_LIMIT);
    localparam int ROWS_W       = $clog2(ROW_LIMIT + 1);

    // configuration port: 64-bit data, one register every 8 bytes
    localparam int ADDR_W    = 6;
    localparam int REG_SHIFT = 3;
    localparam int IDX_W     = ADDR_W - REG_SHIFT;
    localparam int PDATA_W   = 64;

    localparam logic [IDX_W-1:0] REG_TAPS_TOP    = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_TAPS_MID    = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_TAPS_BOTTOM = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_BIAS        = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_RELU_ON     = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_FRAME_COLS  = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_FRAME_ROWS  = IDX_W'(6);

    localparam logic             RELU_RESET = 1'b1;
    localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(28);

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // window entry m*K+n: kernel row m, column n (n = K-1 is the newest)
    typedef logic [K*K-1:0][DATA_W-1:0] t_window;

    typedef struct packed {
        logic [K-1:0][TAPS_W-1:0] taps;
        logic [DATA_W-1:0]        bias;
        logic                     relu_on;
        logic [DIM_W-1:0]         frame_cols;
        logic [DIM_W-1:0]         frame_rows;
    } t_cfg;

    typedef struct packed {
        t_window          window;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_job;

endpackage

// ----- rtl/conv3x3_int16_stream.sv -----
// One output channel of a valid 3x3 convolution over 16-bit samples in raster order. One sample
// is taken per clock while o_stall is low; a result (nine products plus bias, wrapped to 16 bits,
// optional ReLU) passes the front, where the line memory is read on accept and written back the
// cycle after, then the multiply/add pipeline (product, row-sum, output registers). A four-entry
// request queue sits between the two, so o_stall rises only once results back up behind i_stall.
// Frame geometry, taps, bias and ReLU are set through the APB port (8-byte register stride) and
// must only be changed while no sample is in flight. The line memory needs no clearing after reset.
module conv3x3_int16_stream #(
    parameter int MAX_COLS = c3s_pkg::DEF_MAX_COLS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_sample,
    output logic                               o_stall,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [c3s_pkg::DATA_W-1:0]  o_conv_value,
    output logic [c3s_pkg::ROW_W-1:0]          o_out_row,
    output logic [$clog2(MAX_COLS)-1:0]        o_out_col,
    output logic                               o_frame_end,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [c3s_pkg::ADDR_W-1:0]         paddr,
    input  logic [c3s_pkg::PDATA_W-1:0]        pwdata,
    output logic [c3s_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import c3s_pkg::*;

    localparam int CW = $clog2(MAX_COLS);

    t_cfg             r_cfg;
    logic             wr_en;
    logic [IDX_W-1:0] reg_idx;

    logic             push;
    t_job             push_job;
    logic [CW-1:0]    push_col;
    logic             pop;
    t_job             pop_job;
    logic [CW-1:0]    pop_col;
    logic [CNT_W-1:0] q_count;
    logic             q_nonempty;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:REG_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.taps       <= '0;
            r_cfg.bias       <= '0;
            r_cfg.relu_on    <= RELU_RESET;
            r_cfg.frame_cols <= DIM_RESET;
            r_cfg.frame_rows <= DIM_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TAPS_TOP:    r_cfg.taps[0]    <= pwdata[TAPS_W-1:0];
                REG_TAPS_MID:    r_cfg.taps[1]    <= pwdata[TAPS_W-1:0];
                REG_TAPS_BOTTOM: r_cfg.taps[2]    <= pwdata[TAPS_W-1:0];
                REG_BIAS:        r_cfg.bias       <= pwdata[DATA_W-1:0];
                REG_RELU_ON:     r_cfg.relu_on    <= pwdata[0];
                REG_FRAME_COLS:  r_cfg.frame_cols <= pwdata[DIM_W-1:0];
                REG_FRAME_ROWS:  r_cfg.frame_rows <= pwdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TAPS_TOP:    prdata = PDATA_W'(r_cfg.taps[0]);
            REG_TAPS_MID:    prdata = PDATA_W'(r_cfg.taps[1]);
            REG_TAPS_BOTTOM: prdata = PDATA_W'(r_cfg.taps[2]);
            REG_BIAS:        prdata = PDATA_W'(r_cfg.bias);
            REG_RELU_ON:     prdata = PDATA_W'(r_cfg.relu_on);
            REG_FRAME_COLS:  prdata = PDATA_W'(r_cfg.frame_cols);
            REG_FRAME_ROWS:  prdata = PDATA_W'(r_cfg.frame_rows);
            default:         prdata = '0;
        endcase
    end

    c3s_front #(
        .MAX_COLS(MAX_COLS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_sample  (i_sample),
        .o_stall   (o_stall),
        .i_cfg     (r_cfg),
        .i_q_count (q_count),
        .o_push    (push),
        .o_job     (push_job),
        .o_col     (push_col)
    );

    c3s_queue #(
        .MAX_COLS(MAX_COLS)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .i_col      (push_col),
        .i_pop      (pop),
        .o_job      (pop_job),
        .o_col      (pop_col),
        .o_count    (q_count),
        .o_nonempty (q_nonempty)
    );

    c3s_back #(
        .MAX_COLS(MAX_COLS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_nonempty   (q_nonempty),
        .i_job        (pop_job),
        .i_col        (pop_col),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_conv_value (o_conv_value),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_end  (o_frame_end)
    );

endmodule

// ----- rtl/c3s_front.sv -----
module c3s_front #(
    parameter int MAX_COLS = c3s_pkg::DEF_MAX_COLS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [c3s_pkg::DATA_W-1:0]   i_sample,
    output logic                                o_stall,
    input  c3s_pkg::t_cfg                       i_cfg,
    input  logic [c3s_pkg::CNT_W-1:0]           i_q_count,
    output logic                                o_push,
    output c3s_pkg::t_job                       o_job,
    output logic [$clog2(MAX_COLS)-1:0]         o_col
);
    import c3s_pkg::*;

    localparam int CW  = $clog2(MAX_COLS);
    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int FW  = ((CNW > DIM_W) ? CNW : DIM_W) + 1;

    logic [CW-1:0]       r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [CNW-1:0]      cols;
    logic [ROWS_W-1:0]   rows;
    logic [FW-1:0]       fc_ext;
    logic [CNW-1:0]      c_inc;
    logic [ROWS_W-1:0]   r_inc, r_next;
    logic                accept;
    logic                emit;
    logic                last;

    logic                r_b_valid;
    logic [CW-1:0]       r_b_addr;
    logic [DATA_W-1:0]   r_b_sample;
    logic                r_b_emit;
    logic [ROW_W-1:0]    r_b_row;
    logic [CW-1:0]       r_b_col;
    logic                r_b_last;
    logic [2*DATA_W-1:0] r_rd_data;
    t_window             r_window, n_window;

    // entry holds {row before last, last row} of one column
    logic [2*DATA_W-1:0] r_line_mem [MAX_COLS];

    // room for the request in stage B and for one more
    assign o_stall = ((CNT_W+1)'(i_q_count) + (CNT_W+1)'(r_b_valid))
                     >= (CNT_W+1)'(QUEUE_DEPTH);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        fc_ext = FW'(i_cfg.frame_cols);
        if (fc_ext < FW'(K)) begin
            cols = CNW'(K);
        end else if (fc_ext > FW'(MAX_COLS)) begin
            cols = CNW'(MAX_COLS);
        end else begin
            cols = fc_ext[CNW-1:0];
        end
        if (i_cfg.frame_rows < DIM_W'(K)) begin
            rows = ROWS_W'(K);
        end else if (i_cfg.frame_rows > DIM_W'(ROW_LIMIT)) begin
            rows = ROWS_W'(ROW_LIMIT);
        end else begin
            rows = ROWS_W'(i_cfg.frame_rows);
        end
    end

    always_comb begin
        c_inc = CNW'(r_col) + CNW'(1);
        r_inc = ROWS_W'(r_row) + ROWS_W'(1);
        if (c_inc >= cols) begin
            n_col  = '0;
            r_next = r_inc;
        end else begin
            n_col  = c_inc[CW-1:0];
            r_next = ROWS_W'(r_row);
        end
        if (r_next >= rows) begin
            n_row = '0;
        end else begin
            n_row = r_next[ROW_W-1:0];
        end
    end

    assign emit = (r_row >= ROW_W'(K-1)) && (r_col >= CW'(K-1)) &&
                  (ROWS_W'(r_row) < rows) && (CNW'(r_col) < cols);
    assign last = (ROWS_W'(r_row) == rows - ROWS_W'(1)) &&
                  (CNW'(r_col) == cols - CNW'(1));

    always_comb begin
        for (int m = 0; m < K; m++) begin
            for (int n = 0; n < K-1; n++) begin
                n_window[m*K+n] = r_window[m*K+n+1];
            end
        end
        n_window[K-1]   = r_rd_data[2*DATA_W-1:DATA_W];
        n_window[2*K-1] = r_rd_data[DATA_W-1:0];
        n_window[3*K-1] = r_b_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
            r_window  <= '0;
        end else begin
            r_b_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (r_b_valid) begin
                r_window <= n_window;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_addr   <= r_col;
            r_b_sample <= i_sample;
            r_b_emit   <= emit;
            r_b_row    <= r_row - ROW_W'(K-1);
            r_b_col    <= r_col - CW'(K-1);
            r_b_last   <= last;
        end
    end

    // read on accept, write back the shifted column in the cycle after
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_line_mem[r_col];
        end
        if (r_b_valid) begin
            r_line_mem[r_b_addr] <= {r_rd_data[DATA_W-1:0], r_b_sample};
        end
    end

    assign o_push        = r_b_valid && r_b_emit;
    assign o_job.window  = n_window;
    assign o_job.row     = r_b_row;
    assign o_job.last    = r_b_last;
    assign o_col         = r_b_col;

endmodule

// ----- rtl/c3s_queue.sv -----
module c3s_queue #(
    parameter int MAX_COLS = c3s_pkg::DEF_MAX_COLS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  c3s_pkg::t_job                i_job,
    input  logic [$clog2(MAX_COLS)-1:0]  i_col,
    input  logic                         i_pop,
    output c3s_pkg::t_job                o_job,
    output logic [$clog2(MAX_COLS)-1:0]  o_col,
    output logic [c3s_pkg::CNT_W-1:0]    o_count,
    output logic                         o_nonempty
);
    import c3s_pkg::*;

    localparam int CW = $clog2(MAX_COLS);

    t_job              r_jobs [QUEUE_DEPTH];
    logic [CW-1:0]     r_cols [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_jobs[r_wr_ptr] <= i_job;
            r_cols[r_wr_ptr] <= i_col;
        end
    end

    assign o_job      = r_jobs[r_rd_ptr];
    assign o_col      = r_cols[r_rd_ptr];
    assign o_count    = r_count;
    assign o_nonempty = (r_count != '0);

endmodule

// ----- rtl/c3s_back.sv -----
module c3s_back #(
    parameter int MAX_COLS = c3s_pkg::DEF_MAX_COLS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  c3s_pkg::t_cfg                      i_cfg,
    input  logic                               i_nonempty,
    input  c3s_pkg::t_job                      i_job,
    input  logic [$clog2(MAX_COLS)-1:0]        i_col,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [c3s_pkg::DATA_W-1:0]  o_conv_value,
    output logic [c3s_pkg::ROW_W-1:0]          o_out_row,
    output logic [$clog2(MAX_COLS)-1:0]        o_out_col,
    output logic                               o_frame_end
);
    import c3s_pkg::*;

    localparam int CW = $clog2(MAX_COLS);

    logic                      adv_o, en_s, en_p;
    logic [K*K-1:0][2*DATA_W-1:0] prod_full;
    logic [K-1:0][DATA_W-1:0]  row_sum;
    logic [DATA_W-1:0]         total;
    logic [DATA_W-1:0]         result;

    logic                      r_p_valid;
    logic [K*K-1:0][DATA_W-1:0] r_prod;
    logic [ROW_W-1:0]          r_p_row;
    logic [CW-1:0]             r_p_col;
    logic                      r_p_last;

    logic                      r_s_valid;
    logic [K-1:0][DATA_W-1:0]  r_sum;
    logic [ROW_W-1:0]          r_s_row;
    logic [CW-1:0]             r_s_col;
    logic                      r_s_last;

    logic                      r_o_valid;
    logic [DATA_W-1:0]         r_o_value;
    logic [ROW_W-1:0]          r_o_row;
    logic [CW-1:0]             r_o_col;
    logic                      r_o_last;

    assign adv_o = !r_o_valid || !i_stall;
    assign en_s  = !r_s_valid || adv_o;
    assign en_p  = !r_p_valid || en_s;
    assign o_pop = i_nonempty && en_p;

    // only the low 16 bits of each product survive the wrapped sum
    always_comb begin
        for (int m = 0; m < K; m++) begin
            for (int n = 0; n < K; n++) begin
                prod_full[m*K+n] = i_job.window[m*K+n] *
                                   i_cfg.taps[m][n*DATA_W +: DATA_W];
            end
        end
    end

    always_comb begin
        for (int m = 0; m < K; m++) begin
            row_sum[m] = r_prod[m*K] + r_prod[m*K+1] + r_prod[m*K+2];
        end
    end

    assign total  = r_sum[0] + r_sum[1] + r_sum[2] + i_cfg.bias;
    assign result = (i_cfg.relu_on && total[DATA_W-1]) ? '0 : total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_p) begin
                r_p_valid <= o_pop;
            end
            if (en_s) begin
                r_s_valid <= r_p_valid;
            end
            if (adv_o) begin
                r_o_valid <= r_s_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int i = 0; i < K*K; i++) begin
                r_prod[i] <= prod_full[i][DATA_W-1:0];
            end
            r_p_row  <= i_job.row;
            r_p_col  <= i_col;
            r_p_last <= i_job.last;
        end
        if (en_s && r_p_valid) begin
            r_sum    <= row_sum;
            r_s_row  <= r_p_row;
            r_s_col  <= r_p_col;
            r_s_last <= r_p_last;
        end
        if (adv_o && r_s_valid) begin
            r_o_value <= result;
            r_o_row   <= r_s_row;
            r_o_col   <= r_s_col;
            r_o_last  <= r_s_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_conv_value = r_o_value;
    assign o_out_row    = r_o_row;
    assign o_out_col    = r_o_col;
    assign o_frame_end  = r_o_last;

endmodule

// ----- rtl/c3s_checker.sv -----
module c3s_checker #(
    parameter int MAX_COLS = c3s_pkg::DEF_MAX_COLS
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic signed [c3s_pkg::DATA_W-1:0]  o_conv_value,
    input logic [c3s_pkg::ROW_W-1:0]          o_out_row,
    input logic [$clog2(MAX_COLS)-1:0]        o_out_col,
    input logic                               o_frame_end
);
    import c3s_pkg::*;

    // reset empties both pipelines and the queue
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_conv_value) &&
            $stable(o_out_row) && $stable(o_out_col) && $stable(o_frame_end))
        else $error("stalled result changed");

    // indices are the window's top-left corner, so stay K-1 short of the limits
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_out_row) <= ROW_LIMIT - K) &&
                    (32'(o_out_col) <= MAX_COLS - K))
        else $error("result index out of range");

endmodule

bind conv3x3_int16_stream c3s_checker #(
    .MAX_COLS(MAX_COLS)
) u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_conv_value (o_conv_value),
    .o_out_row    (o_out_row),
    .o_out_col    (o_out_col),
    .o_frame_end  (o_frame_end)
);
